>>> rtl/prru_pkg.sv
// Shared widths, mode codes and sequencer states for the permutation rank/unrank core.
package prru_pkg;

   localparam int NIB_W      = 4;
   localparam int PERM_W     = 64;
   localparam int RANK_W     = 45;
   localparam int N_W        = 5;
   localparam int PACK_LIMIT = PERM_W / NIB_W;
   localparam int BYTE_W     = 8;
   localparam int DIV_W      = 48;
   localparam int DIV_CHUNKS = DIV_W / BYTE_W;
   localparam int CHUNK_W    = $clog2(DIV_CHUNKS);

   localparam logic [N_W-1:0] PERM_SIZE_RESET = N_W'(16);

   typedef logic [NIB_W-1:0] nib_type;

   typedef enum logic [1:0] {
      MODE_RANK    = 2'd0,
      MODE_UNRANK  = 2'd1,
      MODE_NEXT    = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RANK,
      ST_DIV,
      ST_SWAP,
      ST_DONE
   } state_type;

endpackage

>>> rtl/permutation_rank_unrank_core.sv
// Permutation rank/unrank core: swap-based mixed-radix sequencer with a shared work register.
//
// One request at a time: start is taken while busy is low, and the single result shows on
// the rsp_ ports for one cycle with rsp_valid; it cannot be held off. With n the effective
// size (perm_size clamped to 1..min(MAX_SIZE,16)), a rank request first checks the word for
// duplicates and range, one element a cycle, then runs n search-and-swap steps with one
// multiply-accumulate each; the steps are skipped when the word is not a permutation. An
// unrank request works through the n-1 mixed-radix digits, each taking six byte steps of the
// shared restoring divider and one swap; a next request makes n-1 swaps driven by the stored
// digit counter, which steps as the result is registered; a restart goes straight to the
// result. A new request may be issued in the cycle the result is shown.
module permutation_rank_unrank_core
   import prru_pkg::*;
#(
   parameter int MAX_SIZE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [PERM_W-1:0] req_perm_in,
   input  logic [RANK_W-1:0] req_rank_in,
   input  logic              csr_wr_en,
   input  logic [N_W-1:0]    csr_wr_data,
   output logic              rsp_valid,
   output logic [PERM_W-1:0] rsp_perm_out,
   output logic [RANK_W-1:0] rsp_rank_out,
   output logic              rsp_bad_perm
);

   localparam int SIZE_LIMIT = (MAX_SIZE < PACK_LIMIT) ? MAX_SIZE : PACK_LIMIT;
   localparam int IDX_W      = $clog2(SIZE_LIMIT);

   logic [N_W-1:0]     size_ff;
   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [N_W-1:0]     r_ff, r_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [NIB_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   val_ff, val_in;
   logic [RANK_W-1:0]  acc_ff, acc_in;
   logic               bad_ff, bad_in;
   logic [SIZE_LIMIT-1:0] seen_ff, seen_in;
   nib_type            e_ff [SIZE_LIMIT];
   nib_type            e_in [SIZE_LIMIT];
   nib_type            cnt_ff [1:SIZE_LIMIT-1];
   nib_type            cnt_in [1:SIZE_LIMIT-1];
   nib_type            cnt_step [1:SIZE_LIMIT-1];
   nib_type            digs [SIZE_LIMIT];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PERM_W-1:0]  rsp_perm_ff, rsp_perm_in;
   logic [RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [N_W-1:0]     n_eff;
   logic [N_W-1:0]     rm1;
   logic [N_W-1:0]     found_m;
   nib_type            sw_raw;
   logic [N_W-1:0]     sw_m;
   logic [IDX_W-1:0]   rd_idx;
   nib_type            rd_nib;
   logic [N_W-1:0]     div_d;
   logic [NIB_W-1:0]   div_rem;
   logic [BYTE_W-1:0]  div_quo;
   logic [RANK_W+N_W-1:0] prod;
   logic [PERM_W-1:0]  perm_pack;

   // effective size: the size register clamped to 1..what the core can pack
   always_comb begin
      if (size_ff == '0) begin
         n_eff = N_W'(1);
      end else if (size_ff > N_W'(SIZE_LIMIT)) begin
         n_eff = N_W'(SIZE_LIMIT);
      end else begin
         n_eff = size_ff;
      end
   end

   always_comb begin
      digs[0] = '0;
      for (int k = 1; k < SIZE_LIMIT; k++) begin
         digs[k] = cnt_ff[k];
      end
   end

   assign rm1 = r_ff - N_W'(1);

   // lowest position below r-1 that holds the value r-1
   always_comb begin
      found_m = rm1;
      for (int j = SIZE_LIMIT - 1; j >= 0; j--) begin
         if (N_W'(j) < rm1 && e_ff[j] == rm1[NIB_W-1:0]) begin
            found_m = N_W'(j);
         end
      end
   end

   assign sw_raw = (mode_ff == MODE_NEXT) ? digs[r_ff[IDX_W-1:0]] : rem_ff;
   assign sw_m   = (N_W'(sw_raw) > r_ff) ? r_ff : N_W'(sw_raw);

   always_comb begin
      unique case (state_ff)
         ST_CHECK: rd_idx = r_ff[IDX_W-1:0];
         ST_RANK:  rd_idx = rm1[IDX_W-1:0];
         default:  rd_idx = sw_m[IDX_W-1:0];
      endcase
   end

   assign rd_nib = e_ff[rd_idx];

   assign div_d = r_ff + N_W'(1);

   prru_div_step u_div (
      .rem_i     (rem_ff),
      .divisor_i (div_d),
      .byte_i    (val_ff[DIV_W-1 -: BYTE_W]),
      .rem_o     (div_rem),
      .quo_o     (div_quo)
   );

   assign prod = (RANK_W + N_W)'(acc_ff) * (RANK_W + N_W)'(r_ff);

   // factorial-base increment over the active digits, wrapping to zero
   always_comb begin : counter_step
      logic carry;
      carry = 1'b1;
      for (int k = 1; k < SIZE_LIMIT; k++) begin
         cnt_step[k] = cnt_ff[k];
         if (N_W'(k) < n_eff && carry) begin
            if (cnt_ff[k] == NIB_W'(k)) begin
               cnt_step[k] = '0;
            end else begin
               cnt_step[k] = cnt_ff[k] + NIB_W'(1);
               carry       = 1'b0;
            end
         end
      end
   end

   always_comb begin
      perm_pack = '0;
      for (int j = 0; j < SIZE_LIMIT; j++) begin
         if (N_W'(j) < n_eff) begin
            perm_pack[NIB_W*j +: NIB_W] = e_ff[j];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      r_in         = r_ff;
      chunk_in     = chunk_ff;
      rem_in       = rem_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      seen_in      = seen_ff;
      e_in         = e_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_perm_in  = rsp_perm_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_bad_in   = rsp_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = mode_type'(req_mode);
               bad_in   = 1'b0;
               seen_in  = '0;
               acc_in   = '0;
               rem_in   = '0;
               chunk_in = '0;
               val_in   = DIV_W'(req_rank_in);
               for (int j = 0; j < SIZE_LIMIT; j++) begin
                  e_in[j] = (mode_type'(req_mode) == MODE_RANK) ?
                            req_perm_in[NIB_W*j +: NIB_W] : NIB_W'(j);
               end
               case (mode_type'(req_mode))
                  MODE_RANK: begin
                     r_in     = '0;
                     state_in = ST_CHECK;
                  end
                  MODE_UNRANK: begin
                     r_in     = N_W'(1);
                     state_in = (n_eff == N_W'(1)) ? ST_DONE : ST_DIV;
                  end
                  MODE_NEXT: begin
                     r_in     = N_W'(1);
                     state_in = (n_eff == N_W'(1)) ? ST_DONE : ST_SWAP;
                  end
                  MODE_RESTART: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if ((N_W'(rd_nib) >= n_eff) || seen_ff[rd_nib[IDX_W-1:0]]) begin
               bad_in = 1'b1;
            end else begin
               seen_in[rd_nib[IDX_W-1:0]] = 1'b1;
            end
            if (r_ff == n_eff - N_W'(1)) begin
               r_in     = n_eff;
               state_in = bad_in ? ST_DONE : ST_RANK;
            end else begin
               r_in = r_ff + N_W'(1);
            end
         end
         ST_RANK: begin
            acc_in = prod[RANK_W-1:0] + RANK_W'(found_m);
            // move the element at r-1 into the found slot, park r-1 at its home
            e_in[found_m[IDX_W-1:0]] = rd_nib;
            e_in[rm1[IDX_W-1:0]]     = rm1[NIB_W-1:0];
            r_in = rm1;
            if (r_ff == N_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            val_in   = {val_ff[DIV_W-BYTE_W-1:0], div_quo};
            rem_in   = div_rem;
            chunk_in = chunk_ff + CHUNK_W'(1);
            if (chunk_ff == CHUNK_W'(DIV_CHUNKS - 1)) begin
               state_in = ST_SWAP;
            end
         end
         ST_SWAP: begin
            // position r still holds r, so only the digit slot needs a read
            e_in[r_ff[IDX_W-1:0]] = rd_nib;
            e_in[sw_m[IDX_W-1:0]] = r_ff[NIB_W-1:0];
            r_in     = r_ff + N_W'(1);
            rem_in   = '0;
            chunk_in = '0;
            if (r_ff == n_eff - N_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = (mode_ff == MODE_NEXT) ? ST_SWAP : ST_DIV;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_perm_in  = (mode_ff == MODE_UNRANK || mode_ff == MODE_NEXT) ? perm_pack : '0;
            rsp_rank_in  = (mode_ff == MODE_RANK && !bad_ff) ? acc_ff : '0;
            rsp_bad_in   = (mode_ff == MODE_RANK) && bad_ff;
            if (mode_ff == MODE_NEXT) begin
               cnt_in = cnt_step;
            end else if (mode_ff == MODE_RESTART) begin
               for (int k = 1; k < SIZE_LIMIT; k++) begin
                  cnt_in[k] = '0;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= PERM_SIZE_RESET;
         for (int k = 1; k < SIZE_LIMIT; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      r_ff        <= r_in;
      chunk_ff    <= chunk_in;
      rem_ff      <= rem_in;
      val_ff      <= val_in;
      acc_ff      <= acc_in;
      bad_ff      <= bad_in;
      seen_ff     <= seen_in;
      e_ff        <= e_in;
      rsp_perm_ff <= rsp_perm_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_perm_out = rsp_perm_ff;
   assign rsp_rank_out = rsp_rank_ff;
   assign rsp_bad_perm = rsp_bad_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_perm) |-> (rsp_rank_out == '0 && rsp_perm_out == '0))
      else $error("bad permutation result carries nonzero payload");

endmodule

>>> rtl/prru_div_step.sv
// Restoring divide step: one byte of the dividend against a small radix per call.
module prru_div_step
   import prru_pkg::*;
(
   input  logic [NIB_W-1:0]  rem_i,
   input  logic [N_W-1:0]    divisor_i,
   input  logic [BYTE_W-1:0] byte_i,
   output logic [NIB_W-1:0]  rem_o,
   output logic [BYTE_W-1:0] quo_o
);

   always_comb begin : restore
      logic [N_W-1:0] part;
      part  = N_W'(rem_i);
      quo_o = '0;
      for (int b = BYTE_W - 1; b >= 0; b--) begin
         // remainder stays below the divisor, so the shift never loses a bit
         part = {part[NIB_W-1:0], byte_i[b]};
         if (part >= divisor_i) begin
            part     = part - divisor_i;
            quo_o[b] = 1'b1;
         end
      end
      rem_o = part[NIB_W-1:0];
   end

endmodule

>>> test/permutation_rank_unrank_checker.sv
`timescale 1ns / 1ps
// Response checker for the permutation rank/unrank core: shadow predictor and in-order compare.
module permutation_rank_unrank_checker
   import prru_pkg::*;
#(
   parameter int MAX_SIZE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [PERM_W-1:0] req_perm_in,
   input  logic [RANK_W-1:0] req_rank_in,
   input  logic              csr_wr_en,
   input  logic [N_W-1:0]    csr_wr_data,
   input  logic              rsp_valid,
   input  logic [PERM_W-1:0] rsp_perm_out,
   input  logic [RANK_W-1:0] rsp_rank_out,
   input  logic              rsp_bad_perm,
   output int                fail_count,
   output int                outstanding
);

   localparam int SIZE_LIMIT = (MAX_SIZE < PACK_LIMIT) ? MAX_SIZE : PACK_LIMIT;
   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      logic [PERM_W-1:0] perm;
      logic [RANK_W-1:0] rank;
      logic              bad;
   } perm_result_type;

   perm_result_type   expected_results [$];
   logic [N_W-1:0]    size_shadow;
   logic [PERM_W-1:0] step_digits;
   int                responses_seen;

   function automatic int clamped_length(logic [N_W-1:0] sz);
      if (sz == '0) return 1;
      if (int'(sz) > SIZE_LIMIT) return SIZE_LIMIT;
      return int'(sz);
   endfunction

   function automatic logic [PERM_W-1:0] swap_nibbles(logic [PERM_W-1:0] w, int a, int b);
      logic [NIB_W-1:0] t;
      t = w[NIB_W*a +: NIB_W];
      w[NIB_W*a +: NIB_W] = w[NIB_W*b +: NIB_W];
      w[NIB_W*b +: NIB_W] = t;
      return w;
   endfunction

   // Build from the identity: position r swaps with position digit r, r = 1..n-1.
   function automatic logic [PERM_W-1:0] perm_from_digits(logic [PERM_W-1:0] digits, int n);
      logic [PERM_W-1:0] w;
      int m;
      w = '0;
      for (int r = 0; r < n; r++) w[NIB_W*r +: NIB_W] = NIB_W'(r);
      for (int r = 1; r < n; r++) begin
         m = int'(digits[NIB_W*r +: NIB_W]);
         if (m > r) m = r;
         w = swap_nibbles(w, r, m);
      end
      return w;
   endfunction

   function automatic perm_result_type rank_of(logic [PERM_W-1:0] packed_perm, int n);
      perm_result_type   res;
      logic [PERM_W-1:0] w;
      logic [PACK_LIMIT-1:0] seen;
      logic [63:0]       acc;
      int                v;
      int                m;
      res = '0;
      seen = '0;
      acc = '0;
      w = packed_perm;
      for (int i = 0; i < n; i++) begin
         v = int'(w[NIB_W*i +: NIB_W]);
         if (v >= n || seen[v]) res.bad = 1'b1;
         else seen[v] = 1'b1;
      end
      if (!res.bad) begin
         // Undo the swaps from the top position down, collecting mixed-radix digits.
         for (int r = n; r > 0; r--) begin
            m = 0;
            while (m < r - 1 && int'(w[NIB_W*m +: NIB_W]) != r - 1) m++;
            acc = acc * r + m;
            w = swap_nibbles(w, r - 1, m);
         end
         res.rank = acc[RANK_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [PERM_W-1:0] unrank_of(logic [RANK_W-1:0] idx, int n);
      logic [63:0]       f;
      logic [63:0]       v;
      logic [PERM_W-1:0] digits;
      f = 64'd1;
      digits = '0;
      for (int r = 2; r <= n; r++) f = f * r;
      v = 64'(idx) % f;
      for (int r = 1; r < n; r++) begin
         digits[NIB_W*r +: NIB_W] = NIB_W'(v % (r + 1));
         v = v / (r + 1);
      end
      return perm_from_digits(digits, n);
   endfunction

   // Predict one response; next advances the shadow counter and restart clears it.
   function automatic perm_result_type predict_response(mode_type mode,
                                                        logic [PERM_W-1:0] perm_v,
                                                        logic [RANK_W-1:0] rank_v);
      perm_result_type res;
      int              n;
      int              d;
      logic            carry;
      res = '0;
      n = clamped_length(size_shadow);
      case (mode)
         MODE_RANK: res = rank_of(perm_v, n);
         MODE_UNRANK: res.perm = unrank_of(rank_v, n);
         MODE_NEXT: begin
            res.perm = perm_from_digits(step_digits << NIB_W, n);
            carry = 1'b1;
            for (int i = 0; i + 1 < n; i++) begin
               if (carry) begin
                  d = int'(step_digits[NIB_W*i +: NIB_W]) + 1;
                  if (d >= i + 2) begin
                     step_digits[NIB_W*i +: NIB_W] = '0;
                  end else begin
                     step_digits[NIB_W*i +: NIB_W] = NIB_W'(d);
                     carry = 1'b0;
                  end
               end
            end
         end
         default: step_digits = '0;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      perm_result_type got;
      perm_result_type want;
      if (reset) begin
         expected_results.delete();
         size_shadow = PERM_SIZE_RESET;
         step_digits = '0;
         fail_count = 0;
         responses_seen = 0;
         outstanding <= 0;
      end else begin
         if (csr_wr_en) size_shadow = csr_wr_data;
         if (rsp_valid) begin
            got.perm = rsp_perm_out;
            got.rank = rsp_rank_out;
            got.bad  = rsp_bad_perm;
            responses_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("%0t: response with no request pending: perm %h rank %0d bad %0b",
                           $realtime, got.perm, got.rank, got.bad);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= SHOW_LIMIT) begin
                     $write("%0t: response %0d mismatch: perm exp %h got %h, ",
                            $realtime, responses_seen, want.perm, got.perm);
                     $display("rank exp %0d got %0d, bad exp %0b got %0b",
                              want.rank, got.rank, want.bad, got.bad);
                  end
               end
            end
         end
         // Queue after the pop so a response never matches the request taken on this edge.
         if (start && !busy)
            expected_results = {expected_results,
                                predict_response(mode_type'(req_mode), req_perm_in,
                                                 req_rank_in)};
         outstanding <= expected_results.size();
      end
   end

endmodule

>>> test/permutation_rank_unrank_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the permutation rank/unrank core: clock, reset, request stimulus, verdict.
module permutation_rank_unrank_core_tb;
   import prru_pkg::*;

   localparam int MAX_SIZE       = 16;
   localparam int SIZE_LIMIT     = (MAX_SIZE < PACK_LIMIT) ? MAX_SIZE : PACK_LIMIT;
   localparam int ITEMS_PER_SIZE = 50;
   localparam int PLAN_LEN       = 18;
   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 120;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_mode;
   logic [PERM_W-1:0] req_perm_in;
   logic [RANK_W-1:0] req_rank_in;
   logic              csr_wr_en;
   logic [N_W-1:0]    csr_wr_data;
   logic              rsp_valid;
   logic [PERM_W-1:0] rsp_perm_out;
   logic [RANK_W-1:0] rsp_rank_out;
   logic              rsp_bad_perm;

   int fail_count;
   int outstanding;
   int requests_sent = 0;
   int sizes_written = 0;
   int idle_cycles   = 0;
   bit steady;

   permutation_rank_unrank_core #(
      .MAX_SIZE(MAX_SIZE)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_mode    (req_mode),
      .req_perm_in (req_perm_in),
      .req_rank_in (req_rank_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_perm_out(rsp_perm_out),
      .rsp_rank_out(rsp_rank_out),
      .rsp_bad_perm(rsp_bad_perm)
   );

   permutation_rank_unrank_checker #(
      .MAX_SIZE(MAX_SIZE)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_mode    (req_mode),
      .req_perm_in (req_perm_in),
      .req_rank_in (req_rank_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_perm_out(rsp_perm_out),
      .rsp_rank_out(rsp_rank_out),
      .rsp_bad_perm(rsp_bad_perm),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int clamped_length(logic [N_W-1:0] sz);
      if (sz == '0) return 1;
      if (int'(sz) > SIZE_LIMIT) return SIZE_LIMIT;
      return int'(sz);
   endfunction

   function automatic logic [63:0] factorial(int n);
      logic [63:0] f;
      f = 64'd1;
      for (int r = 2; r <= n; r++) f = f * r;
      return f;
   endfunction

   // Random permutation in the low n nibbles; random junk above them.
   function automatic logic [PERM_W-1:0] shuffled(int n);
      logic [PERM_W-1:0] w;
      logic [NIB_W-1:0]  t;
      int                j;
      w = {$urandom, $urandom};
      for (int i = 0; i < n; i++) w[NIB_W*i +: NIB_W] = NIB_W'(i);
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = w[NIB_W*i +: NIB_W];
         w[NIB_W*i +: NIB_W] = w[NIB_W*j +: NIB_W];
         w[NIB_W*j +: NIB_W] = t;
      end
      return w;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (steady || p < 40) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Hold the request until the core takes it, then, unless the drawn gap is zero, idle the sender for a while.
   task automatic send_request(mode_type mode, logic [PERM_W-1:0] perm_v,
                               logic [RANK_W-1:0] rank_v);
      int g;
      @(negedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_perm_in <= perm_v;
      req_rank_in <= rank_v;
      do @(posedge clock); while (busy);
      requests_sent++;
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_mode <= 2'($urandom_range(0, 3));
         req_perm_in <= {$urandom, $urandom};
         req_rank_in <= RANK_W'({$urandom, $urandom});
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_size(logic [N_W-1:0] sz);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= sz;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= N_W'($urandom_range(0, 31));
      sizes_written++;
   endtask

   task automatic send_random(int n);
      logic [PERM_W-1:0] perm_v;
      logic [RANK_W-1:0] rank_v;
      int                pick;
      int                a;
      int                b;
      perm_v = {$urandom, $urandom};
      rank_v = RANK_W'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         send_request(MODE_RANK, shuffled(n), rank_v);
      end else if (pick < 38) begin
         // Try to corrupt one element: out of range on a coin flip where possible, else a duplicate.
         perm_v = shuffled(n);
         a = $urandom_range(0, n - 1);
         b = $urandom_range(0, n - 1);
         if (n < PACK_LIMIT && $urandom_range(0, 1) == 1)
            perm_v[NIB_W*a +: NIB_W] = NIB_W'($urandom_range(n, PACK_LIMIT - 1));
         else
            perm_v[NIB_W*a +: NIB_W] = perm_v[NIB_W*b +: NIB_W];
         send_request(MODE_RANK, perm_v, rank_v);
      end else if (pick < 42) begin
         send_request(MODE_RANK, perm_v, rank_v);
      end else if (pick < 62) begin
         send_request(MODE_UNRANK, perm_v, RANK_W'(64'(rank_v) % factorial(n)));
      end else if (pick < 67) begin
         send_request(MODE_UNRANK, perm_v, rank_v);
      end else if (pick < 95) begin
         send_request(MODE_NEXT, perm_v, rank_v);
      end else begin
         send_request(MODE_RESTART, perm_v, rank_v);
      end
   endtask

   initial begin : stimulus
      // Negative entries draw a random size.
      int             size_plan [PLAN_LEN] = '{1, 0, 2, 3, 4, 5, 6, 7, 8, 9, 11, 13, 15, 16,
                                               17, 31, -1, -1};
      logic [N_W-1:0] sz;
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_RANK;
      req_perm_in = '0;
      req_rank_in = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      steady = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset size of 16: full-width words.
      send_request(MODE_RANK, 64'hFEDC_BA98_7654_3210, '0);
      send_request(MODE_RANK, 64'h0123_4567_89AB_CDEF, '1);
      send_request(MODE_RANK, 64'hFEDC_BA98_7644_3210, '0);
      send_request(MODE_RANK, '1, '0);
      send_request(MODE_RANK, '0, '1);
      send_request(MODE_UNRANK, '0, '0);
      send_request(MODE_UNRANK, '1, RANK_W'(factorial(16) - 1));
      send_request(MODE_UNRANK, '0, RANK_W'(factorial(16)));
      send_request(MODE_UNRANK, '0, '1);
      send_request(MODE_NEXT, '0, '0);
      send_request(MODE_NEXT, '1, '1);
      send_request(MODE_NEXT, '0, '0);
      send_request(MODE_RESTART, '1, '1);
      send_request(MODE_NEXT, '0, '0);

      // Three elements: ignored high nibbles, out-of-range, duplicate, counter wrap.
      write_size(N_W'(3));
      send_request(MODE_RANK, 64'hFFFF_FFFF_FFFF_F012, '0);
      send_request(MODE_RANK, 64'h0000_0000_0000_0013, '0);
      send_request(MODE_RANK, 64'h0000_0000_0000_0011, '0);
      send_request(MODE_RESTART, '0, '0);
      repeat (7) send_request(MODE_NEXT, '0, '0);

      for (int k = 0; k < PLAN_LEN; k++) begin
         sz = (size_plan[k] < 0) ? N_W'($urandom_range(0, 31)) : N_W'(size_plan[k]);
         write_size(sz);
         steady = ($urandom_range(0, 3) == 0);
         repeat (ITEMS_PER_SIZE) send_random(clamped_length(sz));
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Run covered %0d requests over %0d size settings (0, 1, 16, 17, 31 included)",
               requests_sent, sizes_written);
      $display("Rank on valid, corrupted and random words; unrank; counter steps with wrap");
      if (fail_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> permutation_rank_unrank_core.f
rtl/prru_pkg.sv
rtl/prru_div_step.sv
rtl/permutation_rank_unrank_core.sv
test/permutation_rank_unrank_checker.sv
test/permutation_rank_unrank_core_tb.sv
